/* design/sfr_pkg.sv */
// Shared types and constants of the servo frame receiver.
`default_nettype none

package sfr_pkg;

    // Servo counts and indexes stay within six bits
    localparam int CNT_W = 6;

    // Frame status codes
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_START   = 3'd1,
        ST_ERROR_REPLY = 3'd2,
        ST_TOO_SHORT   = 3'd3,
        ST_BAD_CHECK   = 3'd4
    } status_t;

    // Configuration register indexes
    localparam logic [1:0] REG_START_BYTE   = 2'd0;
    localparam logic [1:0] REG_ERROR_ID     = 2'd1;
    localparam logic [1:0] REG_SERVO_COUNT  = 2'd2;

    // End-of-frame request from the parser to the result emitter
    typedef struct packed {
        logic             valid;
        status_t          code;
        logic [CNT_W-1:0] count;
    } finish_t;

endpackage

`default_nettype wire

/* design/sfr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sfr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // Hold the last read word until the next read
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* design/sfr_parser.sv */
// Header and payload parser: checksum, position capture, end-of-frame request.
`default_nettype none

module sfr_parser #(
    parameter int HEADER_LEN = 4,
    parameter int MAX_SERVOS = 32,
    localparam int AW = (MAX_SERVOS > 1) ? $clog2(MAX_SERVOS) : 1
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      accept,
    input  wire logic [7:0]                rx_byte,
    input  wire logic [7:0]                start_byte,
    input  wire logic [7:0]                error_reply_id,
    input  wire logic [sfr_pkg::CNT_W-1:0] count,
    output sfr_pkg::finish_t               fin,
    output logic                           wr_en,
    output logic [AW-1:0]                  wr_addr,
    output logic [15:0]                    wr_data
);

    localparam logic [7:0] HDR      = 8'(HEADER_LEN);
    localparam logic [7:0] HDR_LAST = 8'(HEADER_LEN - 1);

    typedef enum logic {
        PH_HEADER,
        PH_PAYLOAD
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] cnt_reg, cnt_next;
    logic [7:0] id_reg, id_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] chk_reg, chk_next;
    logic       start_ok_reg, start_ok_next;
    logic [7:0] xor_reg, xor_next;
    logic [7:0] hold_reg, hold_next;

    logic [7:0] plen;
    logic [6:0] slot;
    logic [7:0] need;
    logic [8:0] cnt_inc;

    assign plen    = len_next - HDR;
    assign slot    = cnt_reg[7:1];
    assign need    = {1'b0, count, 1'b0};
    assign cnt_inc = {1'b0, cnt_reg} + 9'd1;

    always_comb
    begin
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        id_next       = id_reg;
        len_next      = len_reg;
        chk_next      = chk_reg;
        start_ok_next = start_ok_reg;
        xor_next      = xor_reg;
        hold_next     = hold_reg;
        fin           = '{valid: 1'b0, code: sfr_pkg::ST_OK, count: count};
        wr_en         = 1'b0;
        wr_addr       = slot[AW-1:0];
        wr_data       = {hold_reg, rx_byte};

        if (accept)
        begin
            if (phase_reg == PH_HEADER)
            begin
                // Capture header fields; bytes past the check byte are dropped
                case (cnt_reg)
                    8'd0:    start_ok_next = (rx_byte == start_byte);
                    8'd1:    id_next       = rx_byte;
                    8'd2:    len_next      = rx_byte;
                    8'd3:    chk_next      = rx_byte;
                    default: ;
                endcase
                if (cnt_reg != HDR_LAST)
                begin
                    cnt_next = cnt_reg + 8'd1;
                end
                else
                begin
                    cnt_next = 8'd0;
                    if (!start_ok_next)
                    begin
                        fin.valid = 1'b1;
                        fin.code  = sfr_pkg::ST_BAD_START;
                    end
                    else if (id_next == error_reply_id)
                    begin
                        fin.valid = 1'b1;
                        fin.code  = sfr_pkg::ST_ERROR_REPLY;
                    end
                    else if (plen < need)
                    begin
                        fin.valid = 1'b1;
                        fin.code  = sfr_pkg::ST_TOO_SHORT;
                    end
                    else
                    begin
                        xor_next = id_next ^ len_next;
                        if (plen == 8'd0)
                        begin
                            // Empty payload: judge the checksum right away
                            fin.valid = 1'b1;
                            fin.code  = (xor_next == chk_next) ? sfr_pkg::ST_OK
                                                               : sfr_pkg::ST_BAD_CHECK;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
            end
            else
            begin
                xor_next = xor_reg ^ rx_byte;
                // Surplus bytes only enter the checksum
                if (slot < {1'b0, count})
                begin
                    if (!cnt_reg[0])
                    begin
                        hold_next = rx_byte;
                    end
                    else
                    begin
                        wr_en = 1'b1;
                    end
                end
                cnt_next = cnt_inc[7:0];
                if (cnt_inc >= {1'b0, plen})
                begin
                    phase_next = PH_HEADER;
                    cnt_next   = 8'd0;
                    fin.valid  = 1'b1;
                    fin.code   = (xor_next == chk_reg) ? sfr_pkg::ST_OK
                                                       : sfr_pkg::ST_BAD_CHECK;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            cnt_reg      <= 8'd0;
            id_reg       <= 8'd0;
            len_reg      <= 8'd0;
            chk_reg      <= 8'd0;
            start_ok_reg <= 1'b0;
            xor_reg      <= 8'd0;
            hold_reg     <= 8'd0;
        end
        else
        begin
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            id_reg       <= id_next;
            len_reg      <= len_next;
            chk_reg      <= chk_next;
            start_ok_reg <= start_ok_next;
            xor_reg      <= xor_next;
            hold_reg     <= hold_next;
        end
    end

    // Positions are written only while the payload is read
    a_wr_in_payload: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (phase_reg == PH_PAYLOAD && cnt_reg[0]))
        else $error("position write outside payload odd byte");

    // A finished frame restarts the header
    a_fin_restart: assert property (@(posedge clk) disable iff (!rst_n)
        fin.valid |=> (phase_reg == PH_HEADER && cnt_reg == 8'd0))
        else $error("frame end did not return to header");

endmodule

`default_nettype wire

/* design/sfr_emitter.sv */
// End-of-frame result emitter: reads buffered positions and sends the status.
`default_nettype none

module sfr_emitter #(
    parameter int MAX_SERVOS = 32,
    localparam int AW = (MAX_SERVOS > 1) ? $clog2(MAX_SERVOS) : 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire sfr_pkg::finish_t fin,
    output logic                  busy,
    output logic                  rd_en,
    output logic [AW-1:0]         rd_addr,
    input  wire logic [15:0]      rd_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic                  is_status,
    output logic [4:0]            servo_index,
    output logic [15:0]           position,
    output logic [2:0]            frame_status,
    output logic                  last
);

    typedef enum logic [1:0] {
        E_IDLE,
        E_READ,
        E_DATA,
        E_STATUS
    } emit_state_t;

    emit_state_t                 state_reg, state_next;
    logic [sfr_pkg::CNT_W-1:0]   idx_reg, idx_next;
    logic [sfr_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    sfr_pkg::status_t            code_reg, code_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        is_status_reg, is_status_next;
    logic [4:0]                  index_reg, index_next;
    logic [15:0]                 pos_reg, pos_next;
    sfr_pkg::status_t            fstat_reg, fstat_next;
    logic                        last_reg, last_next;
    logic                        out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign busy     = (state_reg != E_IDLE);
    assign rd_en    = (state_reg == E_READ);
    assign rd_addr  = idx_reg[AW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        code_next      = code_reg;
        out_valid_next = out_valid_reg && !out_ready;
        is_status_next = is_status_reg;
        index_next     = index_reg;
        pos_next       = pos_reg;
        fstat_next     = fstat_reg;
        last_next      = last_reg;

        unique case (state_reg)
            E_IDLE:
            begin
                if (fin.valid)
                begin
                    code_next = fin.code;
                    cnt_next  = fin.count;
                    idx_next  = '0;
                    if (fin.code == sfr_pkg::ST_OK && fin.count != '0)
                        state_next = E_READ;
                    else
                        state_next = E_STATUS;
                end
            end
            E_READ:
            begin
                state_next = E_DATA;
            end
            E_DATA:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    is_status_next = 1'b0;
                    index_next     = idx_reg[4:0];
                    pos_next       = rd_data;
                    fstat_next     = sfr_pkg::ST_OK;
                    last_next      = 1'b0;
                    if (idx_reg == cnt_reg - sfr_pkg::CNT_W'(1))
                    begin
                        state_next = E_STATUS;
                    end
                    else
                    begin
                        idx_next   = idx_reg + sfr_pkg::CNT_W'(1);
                        state_next = E_READ;
                    end
                end
            end
            E_STATUS:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    is_status_next = 1'b1;
                    index_next     = 5'd0;
                    pos_next       = 16'd0;
                    fstat_next     = code_reg;
                    last_next      = 1'b1;
                    state_next     = E_IDLE;
                end
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= E_IDLE;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            code_reg      <= sfr_pkg::ST_OK;
            out_valid_reg <= 1'b0;
            is_status_reg <= 1'b0;
            index_reg     <= 5'd0;
            pos_reg       <= 16'd0;
            fstat_reg     <= sfr_pkg::ST_OK;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            code_reg      <= code_next;
            out_valid_reg <= out_valid_next;
            is_status_reg <= is_status_next;
            index_reg     <= index_next;
            pos_reg       <= pos_next;
            fstat_reg     <= fstat_next;
            last_reg      <= last_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign is_status    = is_status_reg;
    assign servo_index  = index_reg;
    assign position     = pos_reg;
    assign frame_status = fstat_reg;
    assign last         = last_reg;

    // A new frame end arrives only while no burst is running
    a_fin_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        fin.valid |-> (state_reg == E_IDLE))
        else $error("frame end request during burst");

    // The final result of a frame is always the status result
    a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (last_reg == is_status_reg))
        else $error("last flag and status flag disagree");

    // Position results never reach past the frame's servo count
    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == E_DATA) |-> (idx_reg < cnt_reg))
        else $error("position index beyond servo count");

endmodule

`default_nettype wire

/* design/servo_frame_receiver.sv */
// Top level of the servo frame receiver: register port, parser, buffer, emitter.
//
//  channel   direction  handshake                 payload
//  ------------------------------------------------------------------------------
//  byte in   request in in_valid / in_ready       rx_byte
//  result    request out out_valid / out_ready    is_status, servo_index, position,
//                                                 frame_status, last
//  config    APB write  psel, penable, pwrite     paddr, pwdata -> prdata
//
// Each header or payload byte is taken on an in_valid / in_ready handshake; positions are
// written to the buffer RAM as the second byte of a pair arrives.
// At frame end the emitter reads the RAM for each position (read, then load the
// output register) and then loads the status; bytes are held off until the
// status has been loaded into the output register.
// A stalled output holds the emitter; the final status may wait in the output
// register while the next frame's bytes are already taken.
// Reset clears control state and registers; the position RAM needs no clearing
// pass, since only entries written by the current frame are ever read.
`default_nettype none

module servo_frame_receiver #(
    parameter int HEADER_LEN = 4,
    parameter int MAX_SERVOS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // byte input
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    // result output
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             is_status,
    output logic [4:0]       servo_index,
    output logic [15:0]      position,
    output logic [2:0]       frame_status,
    output logic             last,
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int AW = (MAX_SERVOS > 1) ? $clog2(MAX_SERVOS) : 1;
    localparam logic [sfr_pkg::CNT_W-1:0] MAX_N = sfr_pkg::CNT_W'(MAX_SERVOS);

    logic [7:0]                start_byte_reg;
    logic [7:0]                error_id_reg;
    logic [sfr_pkg::CNT_W-1:0] servo_count_reg;
    logic [sfr_pkg::CNT_W-1:0] active_count;
    logic [1:0]                reg_idx;
    logic                      cfg_write;

    sfr_pkg::finish_t          fin;
    logic                      busy;
    logic                      accept;
    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic [15:0]               wr_data;
    logic                      rd_en;
    logic [AW-1:0]             rd_addr;
    logic [15:0]               rd_data;

    // Register port: zero wait states, write in the access phase
    assign pready    = 1'b1;
    assign reg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg  <= 8'd255;
            error_id_reg    <= 8'd0;
            servo_count_reg <= sfr_pkg::CNT_W'(20);
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                sfr_pkg::REG_START_BYTE:  start_byte_reg  <= pwdata[7:0];
                sfr_pkg::REG_ERROR_ID:    error_id_reg    <= pwdata[7:0];
                sfr_pkg::REG_SERVO_COUNT: servo_count_reg <= pwdata[sfr_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            sfr_pkg::REG_START_BYTE:  prdata = {24'd0, start_byte_reg};
            sfr_pkg::REG_ERROR_ID:    prdata = {24'd0, error_id_reg};
            sfr_pkg::REG_SERVO_COUNT: prdata = {{(32 - sfr_pkg::CNT_W){1'b0}}, servo_count_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    // Saturate the servo count to the buffer depth
    assign active_count = (servo_count_reg > MAX_N) ? MAX_N : servo_count_reg;

    // Take bytes only while no burst is reading the buffer
    assign in_ready = !busy;
    assign accept   = in_valid && in_ready;

    sfr_parser #(
        .HEADER_LEN (HEADER_LEN),
        .MAX_SERVOS (MAX_SERVOS)
    ) u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .rx_byte        (rx_byte),
        .start_byte     (start_byte_reg),
        .error_reply_id (error_id_reg),
        .count          (active_count),
        .fin            (fin),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data)
    );

    sfr_ram #(
        .WIDTH (16),
        .DEPTH (MAX_SERVOS)
    ) u_pos_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sfr_emitter #(
        .MAX_SERVOS (MAX_SERVOS)
    ) u_emitter (
        .clk          (clk),
        .rst_n        (rst_n),
        .fin          (fin),
        .busy         (busy),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .is_status    (is_status),
        .servo_index  (servo_index),
        .position     (position),
        .frame_status (frame_status),
        .last         (last)
    );

endmodule

`default_nettype wire

/* dv/tb_servo_frame_receiver.sv */
// Testbench for the servo frame receiver: framed byte stimulus, predicted results, checks.
`timescale 1ns / 100ps

module tb_servo_frame_receiver;

    localparam int HDR_LEN      = 4;
    localparam int SERVO_MAX    = 32;
    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 6;
    // Cycles to let pass once nothing is expected: covers an emitter burst
    // over every position plus the status
    localparam int SETTLE_CYCLES = 2 * SERVO_MAX + 16;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int LONG_HOLD     = 400;

    // Kinds of frames the stimulus builds
    typedef enum int {
        FR_GOOD,
        FR_BAD_CHECK,
        FR_BAD_START,
        FR_ERROR_REPLY,
        FR_TOO_SHORT,
        FR_TRUNCATED
    } frame_kind_t;

    // One result as the block should deliver it
    typedef struct {
        logic             is_status;
        logic [4:0]       servo_index;
        logic [15:0]      position;
        sfr_pkg::status_t frame_status;
        logic             last;
    } servo_result_t;

    // Frame parser prediction plus the queue of results still to arrive
    class frame_scoreboard;
        servo_result_t pending_results[$];
        logic [7:0]    cfg_start;
        logic [7:0]    cfg_err;
        logic [5:0]    cfg_count;
        bit            in_payload;
        logic [7:0]    byte_cnt;
        logic [7:0]    fid;
        logic [7:0]    flen;
        logic [7:0]    fchk;
        logic [7:0]    xor_acc;
        logic [7:0]    hi_hold;
        bit            start_ok;
        logic [15:0]   pos_buf [SERVO_MAX];
        int unsigned   mismatches;
        int unsigned   checked;
        int unsigned   status_tally [5];

        function new();
            cfg_start  = 8'hFF;
            cfg_err    = 8'h00;
            cfg_count  = 6'd20;
            in_payload = 0;
            byte_cnt   = '0;
            fid        = '0;
            flen       = '0;
            fchk       = '0;
            xor_acc    = '0;
            hi_hold    = '0;
            start_ok   = 0;
            mismatches = 0;
            checked    = 0;
            foreach (pos_buf[i]) pos_buf[i] = '0;
            foreach (status_tally[i]) status_tally[i] = 0;
        endfunction

        function int unsigned active_servos();
            return (cfg_count > SERVO_MAX) ? SERVO_MAX : cfg_count;
        endfunction

        function void set_config(logic [7:0] start_v, logic [7:0] err_v, logic [5:0] cnt_v);
            cfg_start = start_v;
            cfg_err   = err_v;
            cfg_count = cnt_v;
        endfunction

        function void push_status(sfr_pkg::status_t code);
            servo_result_t r;
            r.is_status    = 1'b1;
            r.servo_index  = '0;
            r.position     = '0;
            r.frame_status = code;
            r.last         = 1'b1;
            pending_results.push_back(r);
        endfunction

        // Judge the checksum and queue the end-of-frame burst
        function void close_frame();
            servo_result_t r;
            in_payload = 0;
            byte_cnt   = '0;
            if (xor_acc != fchk)
            begin
                push_status(sfr_pkg::ST_BAD_CHECK);
                return;
            end
            for (int i = 0; i < active_servos(); i++)
            begin
                r.is_status    = 1'b0;
                r.servo_index  = 5'(i);
                r.position     = pos_buf[i];
                r.frame_status = sfr_pkg::ST_OK;
                r.last         = 1'b0;
                pending_results.push_back(r);
            end
            push_status(sfr_pkg::ST_OK);
        endfunction

        function void note_byte(logic [7:0] b);
            logic [7:0]  plen;
            int unsigned k;
            int unsigned slot;
            if (!in_payload)
            begin
                case (byte_cnt)
                    8'd0: start_ok = (b == cfg_start);
                    8'd1: fid = b;
                    8'd2: flen = b;
                    8'd3: fchk = b;
                    default: ;
                endcase
                byte_cnt = byte_cnt + 8'd1;
                if (int'(byte_cnt) < HDR_LEN) return;
                byte_cnt = '0;
                plen = flen - 8'(HDR_LEN);
                if (!start_ok)
                    push_status(sfr_pkg::ST_BAD_START);
                else if (fid == cfg_err)
                    push_status(sfr_pkg::ST_ERROR_REPLY);
                else if (int'(plen) < 2 * active_servos())
                    push_status(sfr_pkg::ST_TOO_SHORT);
                else
                begin
                    xor_acc = fid ^ flen;
                    if (plen == 0)
                        close_frame();
                    else
                        in_payload = 1;
                end
                return;
            end
            plen = flen - 8'(HDR_LEN);
            k    = byte_cnt;
            slot = k >> 1;
            xor_acc = xor_acc ^ b;
            if (slot < active_servos())
            begin
                if (k[0] == 1'b0)
                    hi_hold = b;
                else
                    pos_buf[slot] = {hi_hold, b};
            end
            byte_cnt = 8'(k + 1);
            if (k + 1 >= plen) close_frame();
        endfunction

        function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v)
            begin
                $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
                mismatches++;
            end
        endfunction

        function void check_result(logic st, logic [4:0] idx, logic [15:0] pos,
                                   logic [2:0] fs, logic lst);
            servo_result_t e;
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected: is_status %0d index %0d status %0d",
                       st, idx, fs);
                mismatches++;
                return;
            end
            e = pending_results.pop_front();
            checked++;
            if (e.is_status) status_tally[e.frame_status]++;
            compare_field("is_status", e.is_status, st);
            compare_field("servo_index", e.servo_index, idx);
            compare_field("position", e.position, pos);
            compare_field("frame_status", e.frame_status, fs);
            compare_field("last", e.last, lst);
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        function bit at_boundary();
            return !in_payload && (byte_cnt == 0);
        endfunction
    endclass

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        is_status;
    logic [4:0]  servo_index;
    logic [15:0] position;
    logic [2:0]  frame_status;
    logic        last;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [3:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    frame_scoreboard sb = new();

    // Idle rates in percent, set per phase, and the long receiver hold-off
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_left = 0;
    int unsigned cycle_count = 0;
    int unsigned bytes_sent = 0;
    int unsigned settings_used = 0;

    servo_frame_receiver #(
        .HEADER_LEN(HDR_LEN),
        .MAX_SERVOS(SERVO_MAX)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .is_status   (is_status),
        .servo_index (servo_index),
        .position    (position),
        .frame_status(frame_status),
        .last        (last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    // Guard the run against a hung handshake
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, sb.outstanding());
            $display("servo_frame_receiver verification failed");
            $finish;
        end
    end

    // Result side: check every accepted result, then pick the next ready.
    // A pending hold-off keeps ready low for its whole length so the block
    // backs up into its input.
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            sb.check_result(is_status, servo_index, position, frame_status, last);
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Offer one byte request, idling first at the sender's rate; leave valid
    // high so a following byte goes out back to back
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    // Drop valid and wait until every expected result is in, then let the
    // emitter settle before anything touches the registers
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write all three registers while the block is idle and mirror them
    task automatic apply_config(input logic [7:0] start_v, input logic [7:0] err_v,
                                input logic [5:0] cnt_v);
        write_reg(sfr_pkg::REG_START_BYTE, {24'd0, start_v});
        write_reg(sfr_pkg::REG_ERROR_ID, {24'd0, err_v});
        write_reg(sfr_pkg::REG_SERVO_COUNT, {26'd0, cnt_v});
        sb.set_config(start_v, err_v, cnt_v);
        settings_used++;
    endtask

    function automatic logic [15:0] pick_position();
        int unsigned r;
        r = $urandom_range(3);
        if (r == 0) return 16'h0000;
        if (r == 1) return 16'hFFFF;
        return 16'($urandom);
    endfunction

    // Build one frame of the given kind under the current settings and send it.
    // Header-only kinds stop after the check byte, as the block ends them there.
    task automatic send_frame(input frame_kind_t kind, input int surplus);
        logic [7:0]  payload[$];
        logic [7:0]  start_v;
        logic [7:0]  fid_v;
        logic [7:0]  len_v;
        logic [7:0]  chk_v;
        logic [15:0] pos_v;
        int unsigned n;
        int unsigned plen;
        int unsigned cut;
        frame_kind_t k;
        k = kind;
        n = sb.active_servos();
        if (k == FR_TOO_SHORT && n == 0) k = FR_GOOD;
        start_v = sb.cfg_start;
        if (k == FR_BAD_START) start_v = sb.cfg_start ^ 8'($urandom_range(1, 255));
        fid_v = 8'($urandom);
        while (fid_v == sb.cfg_err) fid_v = 8'($urandom);
        // error id on a bad start checks that the start test wins
        if (k == FR_ERROR_REPLY || (k == FR_BAD_START && $urandom_range(1) == 1))
            fid_v = sb.cfg_err;
        if (k == FR_TOO_SHORT)
            plen = $urandom_range(0, 2 * n - 1);
        else if (k == FR_ERROR_REPLY && n > 0 && $urandom_range(1) == 1)
            plen = $urandom_range(0, 2 * n - 1);
        else if (k == FR_BAD_START)
            plen = $urandom_range(255);
        else
            plen = 2 * n + surplus;
        len_v = 8'(HDR_LEN + plen);
        for (int i = 0; i < n; i++)
        begin
            pos_v = pick_position();
            payload.push_back(pos_v[15:8]);
            payload.push_back(pos_v[7:0]);
        end
        for (int i = 0; i < surplus; i++) payload.push_back(8'($urandom));
        chk_v = fid_v ^ len_v;
        foreach (payload[i]) chk_v = chk_v ^ payload[i];
        if (k == FR_BAD_CHECK) chk_v = chk_v ^ 8'($urandom_range(1, 255));
        send_byte(start_v);
        send_byte(fid_v);
        send_byte(len_v);
        send_byte(chk_v);
        if (k == FR_GOOD || k == FR_BAD_CHECK)
            foreach (payload[i]) send_byte(payload[i]);
        else if (k == FR_TRUNCATED && payload.size() > 0)
        begin
            // cut the payload short; the next bytes land inside this frame
            cut = $urandom_range(payload.size() - 1);
            for (int i = 0; i < cut; i++) send_byte(payload[i]);
        end
    endtask

    // Mostly well-formed frames with random content, the rest noise and
    // broken frames; finish on a frame boundary so the registers may change
    task automatic run_random(input int unsigned target);
        int unsigned first;
        int unsigned r;
        int          surplus;
        first = bytes_sent;
        while (bytes_sent - first < target)
        begin
            r = $urandom_range(99);
            surplus = ($urandom_range(1) == 0) ? 0 : $urandom_range(1, 3);
            if (r < 58)
                send_frame(FR_GOOD, surplus);
            else if (r < 68)
                send_frame(FR_BAD_CHECK, surplus);
            else if (r < 75)
                send_frame(FR_BAD_START, 0);
            else if (r < 81)
                send_frame(FR_ERROR_REPLY, 0);
            else if (r < 87)
                send_frame(FR_TOO_SHORT, 0);
            else if (r < 94)
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            else
                send_frame(FR_TRUNCATED, surplus);
        end
        while (!sb.at_boundary()) send_byte(8'($urandom));
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: one servo, every status, check order and an odd trailing byte
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        apply_config(8'hA5, 8'h00, 6'd1);
        send_frame(FR_GOOD, 1);
        send_frame(FR_BAD_CHECK, 0);
        send_frame(FR_BAD_START, 0);
        send_frame(FR_ERROR_REPLY, 0);
        send_frame(FR_TOO_SHORT, 0);
        drain();

        // No idling; hold the result side off long enough to back up the input
        apply_config(8'h00, 8'hFF, 6'd3);
        hold_left = LONG_HOLD;
        run_random(40);
        drain();

        // Slow sender
        send_idle_pct = 87;
        apply_config(8'hFF, 8'h00, 6'd1);
        run_random(30);
        drain();

        // Slow receiver
        send_idle_pct  = 0;
        recv_stall_pct = 87;
        apply_config(8'($urandom), 8'($urandom), 6'd2);
        run_random(40);
        drain();

        // Both sides idle now and then; widest servo count
        send_idle_pct  = 22;
        recv_stall_pct = 22;
        apply_config(8'($urandom), 8'($urandom), 6'd32);
        run_random(40);
        drain();

        // Count above the servo maximum saturates
        apply_config(8'($urandom), 8'($urandom), 6'd63);
        run_random(30);
        drain();

        // Zero servos: a good frame carries an empty payload
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        apply_config(8'($urandom), 8'($urandom), 6'd0);
        send_frame(FR_GOOD, 0);
        run_random(20);
        drain();

        $display("covered %0d bytes under %0d register settings, %0d results checked",
                 bytes_sent, settings_used, sb.checked);
        $display("frame ends: ok %0d, bad start %0d, error reply %0d, too short %0d, bad check %0d",
                 sb.status_tally[sfr_pkg::ST_OK], sb.status_tally[sfr_pkg::ST_BAD_START],
                 sb.status_tally[sfr_pkg::ST_ERROR_REPLY],
                 sb.status_tally[sfr_pkg::ST_TOO_SHORT],
                 sb.status_tally[sfr_pkg::ST_BAD_CHECK]);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("servo_frame_receiver verification clean");
        else
            $display("servo_frame_receiver verification failed");
        $finish;
    end

endmodule

/* files.f */
design/sfr_pkg.sv
design/sfr_ram.sv
design/sfr_parser.sv
design/sfr_emitter.sv
design/servo_frame_receiver.sv
dv/tb_servo_frame_receiver.sv
